// ----- sv/mbcn_pkg.sv -----
// Package with shared types, constants and command codes of the centroid normalizer.
`default_nettype none
package mbcn_pkg;
  localparam int MaxVertices = 1024;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = IdxW + 1;
  localparam int CoordW = 24;
  localparam int SumW = 34;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  localparam logic signed [CoordW-1:0] Pos24 = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] Neg24 = -24'sh800000;
  localparam logic signed [CoordW-1:0] ZoffReset = -24'sd131072;

  typedef struct packed {
    logic [1:0] command;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [9:0] vertex_index;
  } in_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [CoordW-1:0] scale_out;
    logic [1:0] status;
  } out_res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic [1:0] axis;
    logic div_mean;
    logic latch_res;
    logic fire;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- sv/mbcn_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module mbcn_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- sv/mbcn_div.sv -----
// Iterative restoring divider for signed numerator by positive divisor, truncating.
`default_nettype none
module mbcn_div import mbcn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [49:0] num,
  input  wire logic [24:0]        den,
  output logic                    done,
  output logic signed [50:0]      quot
);
  logic [49:0] q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] den_r, den_nxt;
  logic [25:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    den_nxt = den_r;
    done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = num[49] ? 50'(-num) : num;
      neg_nxt = num[49];
      rem_nxt = '0;
      cnt_nxt = 6'd50;
      busy_nxt = 1'b1;
      den_nxt = den;
    end else if (busy_r) begin
      trial = {rem_r[24:0], q_r[49]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[48:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[48:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
  end
endmodule
`default_nettype wire

// ----- sv/mbcn_ctrl.sv -----
// Controller state machine sequencing the per-axis divisions.
`default_nettype none
module mbcn_ctrl import mbcn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] command,
  input  wire logic       need_div,
  input  wire dp_stat_t   stat,
  output logic            busy,
  output ctl_cmd_t        cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       mean_r, mean_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    mean_nxt = mean_r;
    cmd = '0;
    cmd.axis = axis_r;
    cmd.div_mean = mean_r;
    cmd.accept = start && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          axis_nxt = 2'd0;
          mean_nxt = (command == CMD_COMPUTE);
          if (command == CMD_COMPUTE || command == CMD_READ) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.latch_res = 1'b1;
        state_nxt = need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          if (axis_r == 2'd2) begin
            state_nxt = S_OUT;
          end else begin
            axis_nxt = axis_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      S_OUT: begin
        cmd.fire = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r <= '0;
      mean_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      mean_r <= mean_nxt;
    end
  end

  a_wait_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (axis_r != 2'd3)) else $error("axis out of range");
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> (state_r == S_IDLE)) else $error("no return to idle");
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_WAIT)) else $error("division not awaited");
endmodule
`default_nettype wire

// ----- sv/mbcn_dp.sv -----
// Datapath: vertex stores, running statistics, divider and result register.
`default_nettype none
module mbcn_dp import mbcn_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire in_req_t                  req,
  input  wire ctl_cmd_t                 cmd,
  input  wire logic                     cfg_we,
  input  wire logic signed [CoordW-1:0] cfg_data,
  output logic                          need_div,
  output dp_stat_t                      stat,
  output out_res_t                      res
);
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic signed [SumW-1:0] sum_r [3];
  logic signed [CoordW-1:0] min_r [3];
  logic signed [CoordW-1:0] max_r [3];
  logic signed [CoordW-1:0] mean_r [3];
  logic [24:0] scale_r;
  logic comp_r, ovf_r;
  logic signed [CoordW-1:0] zoff_r;
  logic [1:0] op_r;
  logic [IdxW-1:0] idx_r;
  logic signed [CoordW-1:0] coord [3];
  logic signed [CoordW-1:0] rd [3];
  logic [CoordW-1:0] ram_rd [3];
  logic load_ok;
  logic [IdxW-1:0] addr;
  out_res_t res_r;
  logic signed [CoordW-1:0] acc_r [3];
  logic [24:0] best;
  logic signed [25:0] ext [3];
  logic signed [49:0] dnum;
  logic [24:0] dden;
  logic signed [50:0] quot;
  logic signed [CoordW-1:0] qsat;
  logic signed [25:0] zsum;

  assign coord[0] = req.coord_x;
  assign coord[1] = req.coord_y;
  assign coord[2] = req.coord_z;
  assign load_ok = cmd.accept && (req.command == CMD_LOAD) && (cnt_r < CntW'(MaxVertices));
  assign addr = load_ok ? cnt_r[IdxW-1:0] : req.vertex_index[IdxW-1:0];

  for (genvar a = 0; a < 3; a++) begin : g_ram
    mbcn_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram (
      .clk(clk), .we(load_ok), .addr(addr), .wdata(coord[a]), .rdata(ram_rd[a]));
    assign rd[a] = $signed(ram_rd[a]);
    assign ext[a] = 26'(max_r[a]) - 26'(min_r[a]);
  end

  always_comb begin
    best = 25'd0;
    for (int a = 0; a < 3; a++) begin
      if (ext[a] > $signed({1'b0, best})) begin
        best = ext[a][24:0];
      end
    end
    if (best == 25'd0) begin
      best = 25'd1;
    end
  end

  always_comb begin
    if (cmd.div_mean) begin
      dnum = 50'(sum_r[cmd.axis]);
      dden = 25'(cnt_r);
    end else begin
      dnum = 50'(26'(acc_r[cmd.axis]) - 26'(mean_r[cmd.axis])) <<< 16;
      dden = scale_r;
    end
  end

  mbcn_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum),
    .den(dden), .done(stat.div_done), .quot(quot));

  assign qsat = (quot > 51'sd8388607) ? Pos24 :
                (quot < -51'sd8388608) ? Neg24 : quot[CoordW-1:0];
  assign zsum = 26'(qsat) + 26'(zoff_r);
  assign need_div = (op_r == CMD_COMPUTE) ? (cnt_r != '0) :
                    (comp_r && ({1'b0, idx_r} < cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      comp_r <= 1'b0;
      ovf_r <= 1'b0;
      scale_r <= 25'd1;
      zoff_r <= ZoffReset;
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= '0;
        min_r[a] <= Pos24;
        max_r[a] <= Neg24;
        mean_r[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        zoff_r <= cfg_data;
      end
      if (cmd.accept) begin
        op_r <= req.command;
        idx_r <= req.vertex_index[IdxW-1:0];
        case (req.command)
          CMD_LOAD: begin
            if (load_ok) begin
              cnt_r <= cnt_r + 1'b1;
              comp_r <= 1'b0;
              for (int a = 0; a < 3; a++) begin
                sum_r[a] <= sum_r[a] + SumW'(coord[a]);
                if (coord[a] < min_r[a]) min_r[a] <= coord[a];
                if (coord[a] > max_r[a]) max_r[a] <= coord[a];
              end
            end else begin
              ovf_r <= 1'b1;
            end
          end
          CMD_CLEAR: begin
            cnt_r <= '0;
            comp_r <= 1'b0;
            ovf_r <= 1'b0;
            scale_r <= 25'd1;
            for (int a = 0; a < 3; a++) begin
              sum_r[a] <= '0;
              min_r[a] <= Pos24;
              max_r[a] <= Neg24;
              mean_r[a] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.latch_res && op_r == CMD_COMPUTE && cnt_r != '0) begin
        scale_r <= best;
        comp_r <= 1'b1;
      end
      if (stat.div_done && cmd.div_mean) begin
        mean_r[cmd.axis] <= quot[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_res) begin
      for (int a = 0; a < 3; a++) begin
        acc_r[a] <= rd[a];
      end
      if (op_r == CMD_COMPUTE) begin
        res_r.status <= (cnt_r == '0) ? ST_EMPTY : (ovf_r ? ST_DROPPED : ST_OK);
        res_r.scale_out <= (cnt_r == '0) ? 24'd1 : best[CoordW-1:0];
      end else begin
        res_r.status <= !comp_r ? ST_EMPTY :
                ({1'b0, idx_r} >= cnt_r) ? ST_BADIDX : (ovf_r ? ST_DROPPED : ST_OK);
        res_r.scale_out <= scale_r[CoordW-1:0];
      end
      res_r.out_x <= '0;
      res_r.out_y <= '0;
      res_r.out_z <= '0;
    end
    if (stat.div_done) begin
      case (cmd.axis)
        2'd0: res_r.out_x <= cmd.div_mean ? quot[CoordW-1:0] : qsat;
        2'd1: res_r.out_y <= cmd.div_mean ? quot[CoordW-1:0] : qsat;
        default: res_r.out_z <= cmd.div_mean ? quot[CoordW-1:0] :
          ((zsum > 26'sd8388607) ? Pos24 : (zsum < -26'sd8388608) ? Neg24 : zsum[CoordW-1:0]);
      endcase
    end
  end

  assign res = res_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxVertices)) else $error("vertex count beyond capacity");
  a_scale_pos: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r != 25'd0) else $error("scale zero");
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load_ok |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count not advanced");
endmodule
`default_nettype wire

// ----- sv/mesh_bbox_centroid_normalize_top.sv -----
// Top level of the mesh centroid and bounding-box normalizer.
// A load or clear request is taken while idle and gives no result. A compute or
// read request that needs division holds busy while it latches operands, runs three
// divisions in one shared 50-step shift-subtract divider, and presents the result.
// A compute with no vertices, or a read before compute or of an unloaded vertex,
// skips the divisions and only latches and presents the result. out_valid pulses in the
// last busy cycle; the receiver cannot stall the result.
`default_nettype none
module mesh_bbox_centroid_normalize_top import mbcn_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_req_t                  in_req,
  output logic                          out_valid,
  output out_res_t                      out_res,
  input  wire logic                     cfg_we,
  input  wire logic signed [CoordW-1:0] cfg_data
);
  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     need_div;

  mbcn_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .command(in_req.command),
    .need_div(need_div), .stat(stat), .busy(busy), .cmd(cmd));

  mbcn_dp u_dp (.clk(clk), .rst_n(rst_n), .req(in_req), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .need_div(need_div), .stat(stat), .res(out_res));

  assign out_valid = cmd.fire;
endmodule
`default_nettype wire

// ----- verif/mesh_bbox_centroid_normalize_top_tb.sv -----
// Testbench for the centroid and bounding-box normalizer: directed table, capacity fill, then random requests.
`timescale 1ns / 1ps
`default_nettype none
module mesh_bbox_centroid_normalize_top_tb;
  import mbcn_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  logic signed [CoordW-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  mesh_bbox_centroid_normalize_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Mirror of the block state.
  logic signed [CoordW-1:0] mx [MaxVertices];
  logic signed [CoordW-1:0] my [MaxVertices];
  logic signed [CoordW-1:0] mz [MaxVertices];
  int unsigned nverts;
  longint sums [3];
  int mins [3];
  int maxs [3];
  int means [3];
  int unsigned cur_scale;
  bit computed, dropped;
  int zoff;

  out_res_t pending_q [$];
  int errors = 0;
  int results_seen = 0;
  int send_idle = 32;
  int n_load = 0, n_comp = 0, n_read = 0, n_clear = 0;

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic wipe_geometry();
    nverts = 0;
    for (int a = 0; a < 3; a++) begin
      sums[a] = 0;
      mins[a] = 8388607;
      maxs[a] = -8388608;
      means[a] = 0;
    end
    cur_scale = 1;
    computed = 0;
    dropped = 0;
  endtask

  function automatic longint norm_axis(int v, int m);
    longint d;
    d = longint'(v) - longint'(m);
    return clamp24((d * 65536) / longint'(cur_scale));
  endfunction

  task automatic predict_request(in_req_t r);
    out_res_t e;
    longint best, ext;
    int c [3];
    e = '0;
    e.scale_out = cur_scale[23:0];
    case (r.command)
      CMD_LOAD: begin
        if (nverts >= MaxVertices) dropped = 1;
        else begin
          c[0] = r.coord_x; c[1] = r.coord_y; c[2] = r.coord_z;
          mx[nverts] = r.coord_x; my[nverts] = r.coord_y; mz[nverts] = r.coord_z;
          for (int a = 0; a < 3; a++) begin
            sums[a] += c[a];
            if (c[a] < mins[a]) mins[a] = c[a];
            if (c[a] > maxs[a]) maxs[a] = c[a];
          end
          nverts++;
          computed = 0;
        end
        return;
      end
      CMD_CLEAR: begin
        wipe_geometry();
        return;
      end
      CMD_COMPUTE: begin
        if (nverts == 0) begin
          e.status = ST_EMPTY;
          e.scale_out = 24'd1;
        end else begin
          best = 0;
          for (int a = 0; a < 3; a++) begin
            means[a] = int'(sums[a] / longint'(nverts));
            ext = longint'(maxs[a]) - longint'(mins[a]);
            if (ext > best) best = ext;
          end
          if (best < 1) best = 1;
          cur_scale = int'(best);
          computed = 1;
          e.out_x = means[0][23:0];
          e.out_y = means[1][23:0];
          e.out_z = means[2][23:0];
          e.scale_out = cur_scale[23:0];
          e.status = dropped ? ST_DROPPED : ST_OK;
        end
      end
      default: begin
        if (!computed) e.status = ST_EMPTY;
        else if (r.vertex_index >= nverts) e.status = ST_BADIDX;
        else begin
          e.out_x = 24'(norm_axis(mx[r.vertex_index], means[0]));
          e.out_y = 24'(norm_axis(my[r.vertex_index], means[1]));
          e.out_z = 24'(clamp24(norm_axis(mz[r.vertex_index], means[2]) + zoff));
          e.status = dropped ? ST_DROPPED : ST_OK;
        end
      end
    endcase
    pending_q = {pending_q, e};
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", out_res);
      end else begin
        out_res_t e;
        e = pending_q.pop_front();
        if (out_res !== e) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected x=%h y=%h z=%h s=%h st=%0d, got x=%h y=%h z=%h s=%h st=%0d",
                     e.out_x, e.out_y, e.out_z, e.scale_out, e.status, out_res.out_x,
                     out_res.out_y, out_res.out_z, out_res.scale_out, out_res.status);
        end
      end
    end
  end

  // start stays high across back-to-back requests and drops only while idling.
  task automatic send(in_req_t r);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_zoff(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    zoff = v;
  endtask

  function automatic in_req_t mk(logic [1:0] cmd, int x, int y, int z, int idx);
    in_req_t r;
    r.command = cmd;
    r.coord_x = x[23:0];
    r.coord_y = y[23:0];
    r.coord_z = z[23:0];
    r.vertex_index = idx[9:0];
    return r;
  endfunction

  function automatic int rnd_coord(int mode);
    case (mode)
      0: return int'($urandom_range(0, 16777215)) - 8388608;
      1: return int'($urandom_range(0, 1023)) - 512;
      default: return $urandom_range(1) ? 8388607 : -8388608;
    endcase
  endfunction

  typedef struct {
    in_req_t r;
    bit has_gold;
    out_res_t gold;
  } table_row_t;

  task automatic random_burst(int count);
    int kind, nload, mode;
    for (int i = 0; i < count; ) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        nload = $urandom_range(1, 8);
        mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
        send(mk(CMD_CLEAR, 0, 0, 0, 0)); n_clear++;
        for (int k = 0; k < nload; k++) begin
          send(mk(CMD_LOAD, rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                  $urandom_range(1023)));
          n_load++;
        end
        send(mk(CMD_COMPUTE, 0, 0, 0, 0)); n_comp++;
        for (int k = 0; k < 3; k++) begin
          send(mk(CMD_READ, 0, 0, 0, $urandom_range(3) == 0 ? $urandom_range(1023)
                                                             : $urandom_range(nload)));
          n_read++;
        end
        i += nload + 5;
      end else begin
        send(mk(2'($urandom_range(3)), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                $urandom_range(1023)));
        i++;
      end
    end
  endtask

  initial begin
    table_row_t rows [$];
    table_row_t row;
    out_res_t g;
    wipe_geometry();
    zoff = ZoffReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    g = '0; g.scale_out = 24'd1; g.status = ST_EMPTY;
    row.r = mk(CMD_COMPUTE, 0, 0, 0, 0); row.has_gold = 1; row.gold = g; rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 0); rows = {rows, row};
    row.has_gold = 0;
    row.r = mk(CMD_LOAD, 8388607, -8388608, 0, 0); rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 0); rows = {rows, row};
    row.r = mk(CMD_LOAD, -8388608, 8388607, -1, 1023); rows = {rows, row};
    row.r = mk(CMD_COMPUTE, 0, 0, 0, 0); rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 0); rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 1); rows = {rows, row};
    g = '0; g.scale_out = 24'hFFFFFF; g.status = ST_BADIDX;
    row.r = mk(CMD_READ, 0, 0, 0, 1023); row.has_gold = 1; row.gold = g; rows = {rows, row};
    row.has_gold = 0;
    row.r = mk(CMD_CLEAR, 0, 0, 0, 0); rows = {rows, row};
    row.r = mk(CMD_LOAD, 65536, 65536, 65536, 0); rows = {rows, row};
    row.r = mk(CMD_LOAD, 65536, 65536, 65536, 0); rows = {rows, row};
    row.r = mk(CMD_COMPUTE, 0, 0, 0, 0); rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 1); rows = {rows, row};
    row.r = mk(CMD_READ, 0, 0, 0, 2); rows = {rows, row};
    row.r = mk(CMD_CLEAR, 0, 0, 0, 0); rows = {rows, row};
    foreach (rows[i]) begin
      send(rows[i].r);
      if (rows[i].has_gold) pending_q[pending_q.size()-1] = rows[i].gold;
    end

    // Fill to capacity so that further loads are dropped.
    for (int k = 0; k < MaxVertices + 3; k++)
      send(mk(CMD_LOAD, rnd_coord(0), rnd_coord(0), rnd_coord(0), 0));
    send(mk(CMD_COMPUTE, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 1023));
    send(mk(CMD_READ, 0, 0, 0, 0));
    send(mk(CMD_CLEAR, 0, 0, 0, 0));

    write_zoff(8388607);
    random_burst(30);
    write_zoff(-8388608);
    send_idle = 47;
    random_burst(30);
    write_zoff(0);
    send_idle = 0;
    random_burst(20);
    write_zoff(int'($urandom_range(0, 16777215)) - 8388608);
    random_burst(20);
    drain();

    $display("Covered %0d loads, %0d computes, %0d reads, %0d clears; %0d results checked.",
             n_load, n_comp, n_read, n_clear, results_seen);
    $display("Included capacity overflow, empty and bad-index reads, and z offset extremes.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/mbcn_pkg.sv
sv/mbcn_ram.sv
sv/mbcn_div.sv
sv/mbcn_ctrl.sv
sv/mbcn_dp.sv
sv/mesh_bbox_centroid_normalize_top.sv
verif/mesh_bbox_centroid_normalize_top_tb.sv
